FILE: sv/bse_pkg.sv
`default_nettype none
package bse_pkg;
  localparam int MaxRowLength = 16;
  localparam int MaxRowCount  = 16;
  localparam int CtrlDepth    = 256;
  localparam int CellCount    = (MaxRowLength > MaxRowCount) ? MaxRowLength : MaxRowCount;
  localparam int CellIdxW     = $clog2(CellCount);
  localparam int DimW         = 5;
  localparam int AddrW        = 8;
  localparam int ParamW       = 17;
  localparam logic [ParamW-1:0] OneQ16 = ParamW'(65536);

  localparam logic [DimW-1:0] CfgRowLength = DimW'(0);
  localparam logic [DimW-1:0] CfgRowCount  = DimW'(1);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic                 load;   // shift the right neighbour into the chain
    logic                 step;   // one de Casteljau pass
    logic [CellIdxW-1:0]  active; // cells below this index update
    logic [ParamW-1:0]    t;
  } cell_ctrl_t;

  function automatic logic signed [31:0] lerp_q16(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [ParamW-1:0] t);
    logic signed [32:0] diff;
    logic signed [49:0] d;
    logic signed [66:0] s;
    begin
      // a*(1-t)+b*t = a*65536 + (b-a)*t
      diff = $signed({b[31], b}) - $signed({a[31], a});
      d = 50'(diff) * $signed({33'd0, t});
      s = 67'($signed({a, 16'h0})) + 67'(d) + 67'sd32768;
      lerp_q16 = s[47:16];
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/bse_cell.sv
`default_nettype none
module bse_cell (
  input  wire logic                       clk,
  input  wire bse_pkg::cell_ctrl_t        ctrl,
  input  wire logic [bse_pkg::CellIdxW-1:0] my_idx,
  input  wire bse_pkg::point_t            right,
  output bse_pkg::point_t                 pt
);
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pt <= right;
    end else if (ctrl.step && (my_idx < ctrl.active)) begin
      pt.x <= bse_pkg::lerp_q16(pt.x, right.x, ctrl.t);
      pt.y <= bse_pkg::lerp_q16(pt.y, right.y, ctrl.t);
      pt.z <= bse_pkg::lerp_q16(pt.z, right.z, ctrl.t);
    end
  end
endmodule
`default_nettype wire

FILE: sv/bezier_surface_evaluator.sv
`default_nettype none
// Bezier surface evaluator, de Casteljau on a chain of interpolation cells.
// s_axis: words with tuser = req_type. tdata from the low bit up:
// point_index, point_x, point_y, point_z, param_u, param_v, zero pad.
// tuser 0 loads control point point_index; tuser 1 evaluates at
// (param_u, param_v) and returns one m_axis word (tdata: x, y, z).
// cfg_we/cfg_idx/cfg_data set row_length (0) and row_count (1), written idle.
// A load goes straight into the control store and leaves the block idle.
// An evaluation reads each row of the grid into the chain one point per cycle
// from the control store (one registered read port, 16 points per row whatever
// its length), runs len-1 passes, and parks the reduced point in a column
// buffer; the column is then shifted in and reduced over cnt-1 passes.
// One item is in work at a time. The result waits in the output register
// while m_axis_tready is low, and no new word is taken until it leaves; the
// next word can be taken in the cycle after that.
// Reset clears the control and sets the dimensions to 4 by 4; stores are undefined.
module bezier_surface_evaluator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_idx,
  input  wire logic [4:0]   cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,  // point_index, point_x, point_y, point_z, param_u, param_v
  input  wire logic [0:0]   s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata   // out_x, out_y, out_z
);
  localparam int CW = bse_pkg::CellIdxW;
  localparam int N  = bse_pkg::CellCount;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RLOAD = 6'b000010, S_RRED = 6'b000100,
    S_CLOAD = 6'b001000, S_CRED = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state;
  logic [4:0] row_length, row_count;
  logic [4:0] len, cnt;
  logic [4:0] cnt_a, row;
  logic [bse_pkg::AddrW-1:0] gaddr;
  logic [bse_pkg::ParamW-1:0] tu, tv;
  logic rd_valid;

  bse_pkg::point_t ctrl_mem [bse_pkg::CtrlDepth];
  bse_pkg::point_t col_mem [bse_pkg::MaxRowCount];
  bse_pkg::point_t rd_pt, feed;
  bse_pkg::point_t chain [N+1];
  bse_pkg::cell_ctrl_t cc;

  wire accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    len = (row_length == 5'd0) ? 5'd1 :
          (row_length > 5'(bse_pkg::MaxRowLength)) ? 5'(bse_pkg::MaxRowLength) : row_length;
    cnt = (row_count == 5'd0) ? 5'd1 :
          (row_count > 5'(bse_pkg::MaxRowCount)) ? 5'(bse_pkg::MaxRowCount) : row_count;
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser[0] == 1'b0) begin
      ctrl_mem[s_axis_tdata[7:0]] <= '{x: s_axis_tdata[39:8], y: s_axis_tdata[71:40],
                                       z: s_axis_tdata[103:72]};
    end
    rd_pt <= ctrl_mem[gaddr];
  end

  // chain: chain[N] is the feed into the last cell
  assign feed = (state == S_CLOAD) ? col_mem[4'(row)] : rd_pt;
  assign chain[N] = feed;
  for (genvar i = 0; i < N; i++) begin : g_cell
    bse_cell u_cell (.clk(clk), .ctrl(cc), .my_idx(CW'(i)), .right(chain[i+1]),
                     .pt(chain[i]));
  end

  // points enter at the top and shift down, so cell 0 holds the first point
  // after N shifts; load always shifts N words, trailing ones are don't-care
  always_comb begin
    cc.load   = (state == S_RLOAD && rd_valid) || (state == S_CLOAD);
    cc.step   = (state == S_RRED) || (state == S_CRED);
    cc.active = CW'(cnt_a);
    cc.t      = (state == S_CRED) ? tu : tv;
  end

  logic [5:0] k;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; row_length <= 5'd4; row_count <= 5'd4;
      m_axis_tvalid <= 1'b0; rd_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == bse_pkg::CfgRowLength[0:0]) row_length <= cfg_data;
        else row_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && s_axis_tuser[0]) begin
            tu <= (s_axis_tdata[120:104] > bse_pkg::OneQ16) ? bse_pkg::OneQ16
                                                            : s_axis_tdata[120:104];
            tv <= (s_axis_tdata[137:121] > bse_pkg::OneQ16) ? bse_pkg::OneQ16
                                                            : s_axis_tdata[137:121];
            row <= 5'd0; gaddr <= '0; k <= 6'd0; rd_valid <= 1'b0;
            state <= S_RLOAD;
          end
        end
        S_RLOAD: begin
          // the registered read leads the load; addresses past the row are harmless
          gaddr <= gaddr + 8'd1;
          if (rd_valid) k <= k + 6'd1;
          if (rd_valid && k == 6'(N-1)) begin
            state <= S_RRED; cnt_a <= len - 5'd1; rd_valid <= 1'b0;
          end else begin
            rd_valid <= 1'b1;
          end
        end
        S_RRED: begin
          // take the row point once every pass has landed
          if (cnt_a == 5'd0) begin
            col_mem[4'(row)] <= chain[0];
            k <= 6'd0;
            if (row == cnt - 5'd1) begin
              row <= 5'd0; state <= S_CLOAD;
            end else begin
              row <= row + 5'd1;
              gaddr <= 8'({5'd0, row + 5'd1} * {5'd0, len});
              state <= S_RLOAD;
            end
          end
          cnt_a <= cnt_a - 5'd1;
        end
        S_CLOAD: begin
          row <= row + 5'd1;
          k <= k + 6'd1;
          if (k == 6'(N-1)) begin
            state <= S_CRED; cnt_a <= cnt - 5'd1;
          end
        end
        S_CRED: begin
          if (cnt_a == 5'd0) begin
            m_axis_tdata <= {chain[0].z, chain[0].y, chain[0].x};
            m_axis_tvalid <= 1'b1; state <= S_OUT;
          end
          cnt_a <= cnt_a - 5'd1;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_load_step: assert property (@(posedge clk) disable iff (rst)
    !(cc.load && cc.step))
    else $error("chain loaded and stepped at once");
endmodule
`default_nettype wire

FILE: verif/bezier_surface_checker.sv
`timescale 1ns / 100ps
module bezier_surface_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_idx,
  input  wire logic [4:0]   cfg_data,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,
  input  wire logic [0:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [95:0]  m_axis_tdata,
  output int                errors,
  output int                points_pending,
  output int                points_checked
);

  logic signed [31:0] grid_x [bse_pkg::CtrlDepth];
  logic signed [31:0] grid_y [bse_pkg::CtrlDepth];
  logic signed [31:0] grid_z [bse_pkg::CtrlDepth];
  logic [4:0]         row_len_reg;
  logic [4:0]         row_cnt_reg;
  bse_pkg::point_t    surface_q [$];

  function automatic logic signed [31:0] blend(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input longint t);
    longint s;
    longint q;
    begin
      s = longint'(a) * (65536 - t) + longint'(b) * t + 32768;
      q = s >>> 16;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      blend = q[31:0];
    end
  endfunction

  function automatic int clamp_dim(input logic [4:0] v, input int maxv);
    begin
      if (v == 0) clamp_dim = 1;
      else if (int'(v) > maxv) clamp_dim = maxv;
      else clamp_dim = int'(v);
    end
  endfunction

  function automatic bse_pkg::point_t surface_point(input logic [16:0] u_raw,
                                                    input logic [16:0] v_raw);
    logic signed [31:0] px [bse_pkg::MaxRowLength];
    logic signed [31:0] py [bse_pkg::MaxRowLength];
    logic signed [31:0] pz [bse_pkg::MaxRowLength];
    logic signed [31:0] cx [bse_pkg::MaxRowCount];
    logic signed [31:0] cy [bse_pkg::MaxRowCount];
    logic signed [31:0] cz [bse_pkg::MaxRowCount];
    int     len;
    int     cnt;
    int     g;
    longint tu;
    longint tv;
    bse_pkg::point_t p;
    begin
      len = clamp_dim(row_len_reg, bse_pkg::MaxRowLength);
      cnt = clamp_dim(row_cnt_reg, bse_pkg::MaxRowCount);
      tu = (u_raw > 17'd65536) ? 65536 : longint'(u_raw);
      tv = (v_raw > 17'd65536) ? 65536 : longint'(v_raw);
      for (int r = 0; r < cnt; r++) begin
        for (int c = 0; c < len; c++) begin
          g = (r * len + c) % bse_pkg::CtrlDepth;
          px[c] = grid_x[g];
          py[c] = grid_y[g];
          pz[c] = grid_z[g];
        end
        for (int j = 1; j < len; j++)
          for (int k = 0; k + j < len; k++) begin
            px[k] = blend(px[k], px[k+1], tv);
            py[k] = blend(py[k], py[k+1], tv);
            pz[k] = blend(pz[k], pz[k+1], tv);
          end
        cx[r] = px[0];
        cy[r] = py[0];
        cz[r] = pz[0];
      end
      for (int j = 1; j < cnt; j++)
        for (int k = 0; k + j < cnt; k++) begin
          cx[k] = blend(cx[k], cx[k+1], tu);
          cy[k] = blend(cy[k], cy[k+1], tu);
          cz[k] = blend(cz[k], cz[k+1], tu);
        end
      p.x = cx[0];
      p.y = cy[0];
      p.z = cz[0];
      surface_point = p;
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    begin
      $display("checker: %s got %h expected %h (point %0d)", what, got, want, points_checked);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    points_pending = 0;
    points_checked = 0;
    row_len_reg = 5'd4;
    row_cnt_reg = 5'd4;
    for (int i = 0; i < bse_pkg::CtrlDepth; i++) begin
      grid_x[i] = '0;
      grid_y[i] = '0;
      grid_z[i] = '0;
    end
  end

  always @(posedge clk) begin
    bse_pkg::point_t want;
    if (rst) begin
      row_len_reg <= 5'd4;
      row_cnt_reg <= 5'd4;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == bse_pkg::CfgRowLength[0:0]) row_len_reg <= cfg_data;
        else row_cnt_reg <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == 1'b0) begin
          grid_x[s_axis_tdata[7:0]] = s_axis_tdata[39:8];
          grid_y[s_axis_tdata[7:0]] = s_axis_tdata[71:40];
          grid_z[s_axis_tdata[7:0]] = s_axis_tdata[103:72];
        end else begin
          surface_q = {surface_q, surface_point(s_axis_tdata[120:104],
                                                s_axis_tdata[137:121])};
          points_pending++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (surface_q.size() == 0) begin
          report("unexpected word x", m_axis_tdata[31:0], '0);
        end else begin
          want = surface_q.pop_front();
          points_pending--;
          if (m_axis_tdata[31:0] !== want.x) report("x", m_axis_tdata[31:0], want.x);
          if (m_axis_tdata[63:32] !== want.y) report("y", m_axis_tdata[63:32], want.y);
          if (m_axis_tdata[95:64] !== want.z) report("z", m_axis_tdata[95:64], want.z);
          points_checked++;
        end
      end
    end
  end

endmodule

FILE: verif/tb_bezier_surface_evaluator.sv
`timescale 1ns / 100ps
module tb_bezier_surface_evaluator;

  localparam int StallLimit = 20000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [0:0]   cfg_idx;
  logic [4:0]   cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;   // point_index, point_x, point_y, point_z, param_u, param_v
  logic [0:0]   s_axis_tuser;   // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;   // out_x, out_y, out_z
  int           errors;
  int           points_pending;
  int           points_checked;

  bit           written [bse_pkg::CtrlDepth];
  bit           no_idle;
  int           grid_len;
  int           grid_cnt;
  int           ready_wait;
  int           idle_cycles;
  int           loads_sent;
  int           evals_sent;

  bezier_surface_evaluator dut (.*);

  bezier_surface_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver side: draw a stall for every word taken
  always @(posedge clk) begin
    int w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      w = no_idle ? 0 : $urandom_range(0, 17);
      ready_wait <= w;
      if (w > 0) m_axis_tready <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      if (ready_wait == 1) m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: watchdog, no word moved for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int clamp_dim(input int v, input int maxv);
    clamp_dim = (v < 1) ? 1 : ((v > maxv) ? maxv : v);
  endfunction

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 5))
      0: coord = 32'h7fffffff;
      1: coord = 32'h80000000;
      2: coord = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: coord = $urandom;
    endcase
  endfunction

  function automatic logic [16:0] param();
    case ($urandom_range(0, 7))
      0: param = 17'd0;
      1: param = 17'd65536;
      2: param = 17'($urandom_range(65537, 131071));
      default: param = 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send(input logic req, input logic [143:0] data);
    int gap;
    begin
      s_axis_tuser <= req;
      s_axis_tdata <= data;
      s_axis_tvalid <= 1'b1;
      do @(posedge clk); while (!s_axis_tready);
      if (req == 1'b0) loads_sent++;
      else evals_sent++;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // a load ignores the parameter bits; keep them toggling
  task automatic load_point(input int idx, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    logic [33:0] junk;
    begin
      junk = 34'({$urandom, $urandom});
      written[idx] = 1'b1;
      send(1'b0, {6'd0, junk, z, y, x, 8'(idx)});
    end
  endtask

  // evaluation ignores the point bits below param_u; keep them toggling
  task automatic evaluate(input logic [16:0] u, input logic [16:0] v);
    logic [103:0] junk;
    begin
      junk = {$urandom, $urandom, $urandom, 8'($urandom)};
      send(1'b1, {6'd0, v, u, junk});
    end
  endtask

  task automatic fill_grid();
    begin
      for (int i = 0; i < grid_len * grid_cnt; i++)
        if (!written[i]) load_point(i, coord(), coord(), coord());
    end
  endtask

  task automatic set_dims(input logic [4:0] len, input logic [4:0] cnt);
    begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (points_pending != 0) @(posedge clk);
      repeat (700) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= bse_pkg::CfgRowLength[0:0];
      cfg_data <= len;
      @(posedge clk);
      cfg_idx <= bse_pkg::CfgRowCount[0:0];
      cfg_data <= cnt;
      @(posedge clk);
      cfg_we <= 1'b0;
      grid_len = clamp_dim(int'(len), bse_pkg::MaxRowLength);
      grid_cnt = clamp_dim(int'(cnt), bse_pkg::MaxRowCount);
    end
  endtask

  task automatic random_phase(input int n);
    int idx;
    begin
      fill_grid();
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          evaluate(param(), param());
        end else begin
          // write anywhere; points outside the grid just mark more cells written
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, grid_len * grid_cnt - 1);
          load_point(idx, coord(), coord(), coord());
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    no_idle = 1'b0;
    grid_len = 4;
    grid_cnt = 4;
    loads_sent = 0;
    evals_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset dims 4 x 4: extreme corners, then every parameter extreme
    for (int i = 0; i < 16; i++)
      load_point(i, (i % 2) ? 32'h7fffffff : 32'h80000000,
                 (i % 3) ? 32'h80000000 : 32'h7fffffff, 32'(i * 32'h00010000));
    evaluate(17'd0, 17'd0);
    evaluate(17'd65536, 17'd65536);
    evaluate(17'h1ffff, 17'h1ffff);
    evaluate(17'd32768, 17'd1);
    evaluate(17'd65535, 17'd65537);

    // single point grid passes the point through
    set_dims(5'd1, 5'd1);
    load_point(0, 32'h12345678, 32'hfedcba98, 32'h80000000);
    evaluate(17'd12345, 17'd54321);

    // register values out of range: 0 acts as 1, 31 as the maximum
    set_dims(5'd0, 5'd31);
    random_phase(8);
    set_dims(5'd16, 5'd2);
    random_phase(10);
    set_dims(5'd16, 5'd1);
    random_phase(15);
    set_dims(5'd1, 5'd16);
    random_phase(15);
    set_dims(5'd31, 5'd0);
    random_phase(15);
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      set_dims(5'($urandom_range(2, 5)), 5'($urandom_range(2, 5)));
      random_phase(30);
    end
    no_idle = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    $display("tb: %0d loads and %0d evaluations sent, %0d surface points checked",
             loads_sent, evals_sent, points_checked);
    $display("tb: rows and columns of 1 to 16 points, parameters at 0, one and above one");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bse_pkg.sv
sv/bse_cell.sv
sv/bezier_surface_evaluator.sv
verif/bezier_surface_checker.sv
verif/tb_bezier_surface_evaluator.sv
